/* rtl/core/mandelbrot_escape_time_unit_macros.svh */
// Assertion macros shared by the escape-time unit.
// Files that check their own logic include this header by bare name.
`ifndef MANDELBROT_ESCAPE_TIME_UNIT_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, muted during reset.
`define MET_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock, muted during reset.
`define MET_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/met_pkg.sv */
// Shared types, constants and helpers of the escape-time unit.
// Used by the controller, the datapath and the top level; depends on nothing.
package met_pkg;

	localparam int IMAGE_SIZE = 1024;
	localparam int FRAC_BITS  = 28;
	localparam int COORD_BITS = FRAC_BITS + 4;
	localparam int IDX_W      = 10;
	localparam int ITER_W     = 16;
	localparam int STEP_W     = 31;
	localparam int ORIGIN_W   = 32;
	localparam int GREY_W     = 8;
	localparam int OFF_W      = STEP_W + IDX_W;
	localparam int PROD_W     = 2 * COORD_BITS;
	localparam int WIDE_W     = OFF_W + 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 32;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [PROD_W-1:0]     prod_t;
	typedef logic signed [WIDE_W-1:0]     wide_t;

	localparam wide_t ESCAPE_LIMIT = wide_t'(4) <<< FRAC_BITS;
	localparam wide_t COORD_MAX =
		{{(WIDE_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
	localparam wide_t COORD_MIN = ~COORD_MAX;
	// Added to a negative product so that the shift truncates toward zero.
	localparam prod_t AB_BIAS = (prod_t'(1) <<< (FRAC_BITS - 1)) - prod_t'(1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ORIGIN_REAL = 2'd0,
		CFG_ORIGIN_IMAG = 2'd1,
		CFG_PIXEL_STEP  = 2'd2,
		CFG_MAX_ITER    = 2'd3
	} cfg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_POINT = 5'b00010,
		ST_MUL   = 5'b00100,
		ST_STEP  = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	typedef struct packed {
		logic capture;
		logic point;
		logic mul;
		logic update;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic limit_zero;
		logic escape;
		logic last_iter;
		logic out_busy;
	} dp_status_t;

	// Clamp a wide intermediate to the signed coordinate range.
	function automatic coord_t sat_coord(input wide_t v);
		priority if (v > COORD_MAX) begin
			return COORD_MAX[COORD_BITS-1:0];
		end else if (v < COORD_MIN) begin
			return COORD_MIN[COORD_BITS-1:0];
		end else begin
			return v[COORD_BITS-1:0];
		end
	endfunction

endpackage

/* rtl/core/met_ctrl.sv */
// Sequencer of the escape-time unit: walks one pixel through point setup,
// the multiply and update steps of each iteration, and result hand-off. Uses met_pkg.
module met_ctrl
	import met_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) begin
					state_nxt = ST_POINT;
				end
			end
			ST_POINT: begin
				cmd.point = 1'b1;
				state_nxt = status.limit_zero ? ST_DONE : ST_MUL;
			end
			ST_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = ST_STEP;
			end
			ST_STEP: begin
				if (status.escape) begin
					state_nxt = ST_DONE;
				end else begin
					cmd.update = 1'b1;
					state_nxt  = status.last_iter ? ST_DONE : ST_MUL;
				end
			end
			ST_DONE: begin
				if (!status.out_busy) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/core/met_dp.sv */
// Datapath of the escape-time unit: point scaling, the three squaring
// products, escape test, saturating update and the output register. Uses met_pkg.
module met_dp
	import met_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  dp_cmd_t                    cmd,
	output dp_status_t                 status,
	input  logic        [IDX_W-1:0]    row,
	input  logic        [IDX_W-1:0]    col,
	input  logic signed [ORIGIN_W-1:0] origin_real,
	input  logic signed [ORIGIN_W-1:0] origin_imag,
	input  logic        [STEP_W-1:0]   pixel_step,
	input  logic        [ITER_W-1:0]   max_iter,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic        [ITER_W-1:0]   out_iterations,
	output logic                       out_inside,
	output logic        [GREY_W-1:0]   out_grey
);

	logic [IDX_W-1:0]  row_idx, col_idx;
	logic [OFF_W-1:0]  off_re_q, off_im_q;
	coord_t            cr_q, ci_q, a_q, b_q;
	prod_t             paa_q, pbb_q, pab_q;
	logic [ITER_W-1:0] k_q;
	logic              out_valid_q;
	logic [ITER_W-1:0] out_iter_q;
	logic              out_inside_q;
	logic [GREY_W-1:0] out_grey_q;

	prod_t             pab_adj;
	wide_t             a2, b2, ab2, mag;
	coord_t            new_a, new_b;
	logic [ITER_W-1:0] k_inc;
	logic              in_set;

	assign row_idx = IDX_W'(row % IMAGE_SIZE);
	assign col_idx = IDX_W'(col % IMAGE_SIZE);

	// Squares are never negative, so a plain shift truncates them toward zero.
	// The cross product is doubled by shifting one bit less.
	assign pab_adj = pab_q + (pab_q[PROD_W-1] ? AB_BIAS : prod_t'(0));
	assign a2      = wide_t'(paa_q >>> FRAC_BITS);
	assign b2      = wide_t'(pbb_q >>> FRAC_BITS);
	assign ab2     = wide_t'(pab_adj >>> (FRAC_BITS - 1));
	assign mag     = a2 + b2;
	assign new_a   = sat_coord(a2 - b2 + wide_t'(cr_q));
	assign new_b   = sat_coord(ab2 + wide_t'(ci_q));
	assign k_inc   = k_q + ITER_W'(1);
	assign in_set  = (k_q == max_iter);

	assign status.limit_zero = (max_iter == '0);
	assign status.escape     = (mag > ESCAPE_LIMIT);
	assign status.last_iter  = (k_inc == max_iter);
	assign status.out_busy   = out_valid_q && !out_ready;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			off_re_q <= OFF_W'(pixel_step) * OFF_W'(col_idx);
			off_im_q <= OFF_W'(pixel_step) * OFF_W'(row_idx);
		end
		if (cmd.point) begin
			cr_q <= sat_coord(wide_t'(origin_real) + wide_t'(off_re_q));
			ci_q <= sat_coord(wide_t'(origin_imag) + wide_t'(off_im_q));
			a_q  <= sat_coord(wide_t'(origin_real) + wide_t'(off_re_q));
			b_q  <= sat_coord(wide_t'(origin_imag) + wide_t'(off_im_q));
			k_q  <= '0;
		end
		if (cmd.mul) begin
			paa_q <= prod_t'(a_q) * prod_t'(a_q);
			pbb_q <= prod_t'(b_q) * prod_t'(b_q);
			pab_q <= prod_t'(a_q) * prod_t'(b_q);
		end
		if (cmd.update) begin
			a_q <= new_a;
			b_q <= new_b;
			k_q <= k_inc;
		end
		if (cmd.load_out) begin
			out_iter_q   <= k_q;
			out_inside_q <= in_set;
			out_grey_q   <= in_set ? '0 : k_q[GREY_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_iterations = out_iter_q;
	assign out_inside     = out_inside_q;
	assign out_grey       = out_grey_q;

endmodule

/* rtl/core/mandelbrot_escape_time_unit.sv */
// Escape-time unit: one pixel per transaction; each iteration is a multiply step
// and then an update step. The next transaction is taken only once the pixel has
// run its escape checks (iterations + 1 on escape, the limit when inside) and its
// result is in the output register; a held result stalls that hand-off.
// Asynchronous active-low reset loads the register defaults and empties the unit.
`include "mandelbrot_escape_time_unit_macros.svh"

module mandelbrot_escape_time_unit
	import met_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Pixel input stream.
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [9:0] row, [19:10] col, [23:20] zero
	// Result stream.
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [15:0] iterations, [16] inside_res,
	                                             // [24:17] grey, [31:25] zero
	// Register write channel.
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Configuration registers. Writes are only expected while no pixel is in
	// flight, so the datapath reads them directly without a shadow copy.
	logic signed [ORIGIN_W-1:0] origin_real_q, origin_imag_q;
	logic        [STEP_W-1:0]   pixel_step_q;
	logic        [ITER_W-1:0]   max_iter_q;

	dp_cmd_t           cmd;
	dp_status_t        status;
	logic [ITER_W-1:0] res_iterations;
	logic              res_inside;
	logic [GREY_W-1:0] res_grey;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_real_q <= -ORIGIN_W'(32'sd570425344);
			origin_imag_q <= -ORIGIN_W'(32'sd402653184);
			pixel_step_q  <= STEP_W'(786432);
			max_iter_q    <= ITER_W'(256);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ORIGIN_REAL: origin_real_q <= cfg_data[ORIGIN_W-1:0];
				CFG_ORIGIN_IMAG: origin_imag_q <= cfg_data[ORIGIN_W-1:0];
				CFG_PIXEL_STEP:  pixel_step_q  <= cfg_data[STEP_W-1:0];
				CFG_MAX_ITER:    max_iter_q    <= cfg_data[ITER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The sequencer takes a pixel only from its idle state; the datapath owns
	// the output register, so a finished result may wait while the next pixel
	// is already accepted and iterating.
	met_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	met_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.row            (s_axis_tdata[IDX_W-1:0]),
		.col            (s_axis_tdata[2*IDX_W-1:IDX_W]),
		.origin_real    (origin_real_q),
		.origin_imag    (origin_imag_q),
		.pixel_step     (pixel_step_q),
		.max_iter       (max_iter_q),
		.out_ready      (m_axis_tready),
		.out_valid      (m_axis_tvalid),
		.out_iterations (res_iterations),
		.out_inside     (res_inside),
		.out_grey       (res_grey)
	);

	assign m_axis_tdata = {
		(OUT_DATA_W-ITER_W-1-GREY_W)'(0), res_grey, res_inside, res_iterations
	};

	// Only one datapath command is issued in any cycle.
	`MET_ASSERT_NOW(a_cmd_exclusive, 1'b1,
		$onehot0({cmd.capture, cmd.point, cmd.mul, cmd.update, cmd.load_out}),
		"more than one datapath command in a cycle")

	// A pixel transaction moves the sequencer out of idle.
	`MET_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready,
		!s_axis_tready, "input still ready right after a pixel transaction")

	// Loading the result register always presents a result.
	`MET_ASSERT_NEXT(a_load_shows_result, cmd.load_out, m_axis_tvalid,
		"result register loaded but no result presented")

	// A point that stays inside carries a zero grey level.
	`MET_ASSERT_NOW(a_inside_black, m_axis_tvalid && m_axis_tdata[ITER_W],
		m_axis_tdata[ITER_W+GREY_W:ITER_W+1] == '0, "inside point with nonzero grey")

endmodule

/* test/mandelbrot_escape_time_checker.sv */
// Checker for the escape-time unit: watches the register, pixel and result channels,
// predicts each pixel's escape count and compares it with the result stream.
// Depends on met_pkg for widths and register indexes.
`timescale 1ns / 1ps

module mandelbrot_escape_time_checker
	import met_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    pending,
	output int                    fail_count
);

	// Laid out as on the result stream: grey on top, iterations at the bottom.
	typedef struct packed {
		logic [GREY_W-1:0] grey;
		logic              inside_res;
		logic [ITER_W-1:0] iterations;
	} pixel_result_t;

	localparam longint COORD_HI   = (longint'(1) <<< (COORD_BITS - 1)) - 1;
	localparam longint COORD_LO   = -COORD_HI - 1;
	localparam longint ESCAPE_SQR = longint'(4) <<< FRAC_BITS;

	logic signed [ORIGIN_W-1:0] view_real;
	logic signed [ORIGIN_W-1:0] view_imag;
	logic [STEP_W-1:0]          view_step;
	logic [ITER_W-1:0]          iter_limit;

	pixel_result_t escape_q[$];
	int            mismatches = 0;

	assign fail_count = mismatches;

	function automatic longint clamp_coord(input longint v);
		if (v > COORD_HI) begin
			return COORD_HI;
		end
		if (v < COORD_LO) begin
			return COORD_LO;
		end
		return v;
	endfunction

	// Fixed-point product, truncated toward zero; 128 bits hold 2*a*b without overflow.
	function automatic longint fixed_mul(input longint x, input longint y);
		logic signed [127:0] wx;
		logic signed [127:0] wy;
		logic signed [127:0] prod;
		logic signed [127:0] mag;
		wx = x;
		wy = y;
		prod = wx * wy;
		if (prod < 0) begin
			mag = -prod;
			prod = -(mag >>> FRAC_BITS);
		end else begin
			prod = prod >>> FRAC_BITS;
		end
		return longint'(prod);
	endfunction

	function automatic pixel_result_t escape_time(input logic [IDX_W-1:0] row,
			input logic [IDX_W-1:0] col);
		longint        cr;
		longint        ci;
		longint        zr;
		longint        zi;
		longint        zr2;
		longint        zi2;
		longint        next_zi;
		int unsigned   k;
		pixel_result_t res;
		ci = clamp_coord(longint'(view_imag) + longint'(view_step) * longint'(row));
		cr = clamp_coord(longint'(view_real) + longint'(view_step) * longint'(col));
		zr = cr;
		zi = ci;
		k = 0;
		while (k < int'(iter_limit)) begin
			zr2 = fixed_mul(zr, zr);
			zi2 = fixed_mul(zi, zi);
			if (zr2 + zi2 > ESCAPE_SQR) begin
				break;
			end
			next_zi = clamp_coord(fixed_mul(zr * 2, zi) + ci);
			zr = clamp_coord(zr2 - zi2 + cr);
			zi = next_zi;
			k++;
		end
		res.iterations = k[ITER_W-1:0];
		res.inside_res = (k == int'(iter_limit));
		res.grey = res.inside_res ? '0 : k[GREY_W-1:0];
		return res;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_result_t want;
		pixel_result_t got;
		if (!arst_n) begin
			view_real = -32'sd570425344;
			view_imag = -32'sd402653184;
			view_step = 31'd786432;
			iter_limit = 16'd256;
			escape_q.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_ORIGIN_REAL: view_real = cfg_data;
					CFG_ORIGIN_IMAG: view_imag = cfg_data;
					CFG_PIXEL_STEP:  view_step = cfg_data[STEP_W-1:0];
					CFG_MAX_ITER:    iter_limit = cfg_data[ITER_W-1:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				escape_q = {escape_q, escape_time(s_axis_tdata[IDX_W-1:0],
					s_axis_tdata[2*IDX_W-1:IDX_W])};
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[ITER_W+GREY_W:0];
				if (escape_q.size() == 0) begin
					report_mismatch("result count (nothing pending)", 1, 0);
				end else begin
					want = escape_q.pop_front();
					if (got.iterations != want.iterations) begin
						report_mismatch("iterations", got.iterations, want.iterations);
					end
					if (got.inside_res != want.inside_res) begin
						report_mismatch("inside_res", got.inside_res, want.inside_res);
					end
					if (got.grey != want.grey) begin
						report_mismatch("grey", got.grey, want.grey);
					end
				end
				if (m_axis_tdata[OUT_DATA_W-1:ITER_W+GREY_W+1] != '0) begin
					report_mismatch("tdata padding", m_axis_tdata[OUT_DATA_W-1:ITER_W+GREY_W+1], 0);
				end
			end
			pending <= escape_q.size();
		end
	end

endmodule

/* test/mandelbrot_escape_time_unit_tb.sv */
// Testbench top for the escape-time unit: clock, reset, register programming,
// pixel stimulus with random idling on both streams, and the final verdict.
// Depends on met_pkg, the unit itself and mandelbrot_escape_time_checker.
`timescale 1ns / 1ps

module mandelbrot_escape_time_unit_tb;
	import met_pkg::*;

	// Far above the slowest legal run: all the pixel work of the regression
	// plus one pixel at the full 16-bit iteration limit.
	localparam int CYCLE_LIMIT = 8000000;
	// Cycles allowed after the last result before the unit counts as idle.
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_PIXELS = 110;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int pending;
	int fail_count;
	int cycle_count = 0;
	// Largest idle gap either side may draw; zero gives back-to-back stretches.
	int gap_max = 8;

	mandelbrot_escape_time_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	mandelbrot_escape_time_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.pending       (pending),
		.fail_count    (fail_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Result side back-pressure. Every edge decides tready once: after a
	// completed transaction a fresh stall length is drawn and tready stays low
	// until that stall has run out, otherwise it stays high.
	initial begin
		int hold;
		hold = 0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				hold = $urandom_range(0, gap_max);
			end
			if (hold > 0) begin
				m_axis_tready <= 1'b0;
				hold--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Offers one pixel. tvalid is left high after the transaction; the next
	// call either reuses it at once (no gap) or drops it for the gap, so a
	// single nonblocking write reaches tvalid in any one time step.
	task automatic send_pixel(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(IN_DATA_W - 2*IDX_W){1'b0}}, col, row};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Stops the pixel stream and waits until every predicted result has been
	// taken, then for the settle time so the unit is surely back at rest.
	task automatic drain_unit();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes all four registers back to back; cfg_valid stays high between
	// transactions and drops only after the last one.
	task automatic program_unit(input logic [31:0] re, input logic [31:0] im,
			input logic [31:0] stp, input logic [31:0] lim);
		logic [31:0] vals [4];
		cfg_idx_t    regs [4];
		vals = '{re, im, stp, lim};
		regs = '{CFG_ORIGIN_REAL, CFG_ORIGIN_IMAG, CFG_PIXEL_STEP, CFG_MAX_ITER};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [31:0] re;
		logic [31:0] im;
		logic [31:0] stp;
		logic [15:0] lim;
		int          pick;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;

		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_ORIGIN_REAL;
		cfg_data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset view: image corners, a point just beside the origin of the plane that
		// runs the full default limit, and an ordinary pixel.
		gap_max = 8;
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd1023);
		send_pixel(10'd512, 10'd725);
		send_pixel(10'd0, 10'd1023);
		send_pixel(10'd1023, 10'd0);
		send_pixel(10'd511, 10'd300);
		drain_unit();

		// Zero limit, with the most negative and most positive origins and the
		// largest step so that the far corner saturates as well.
		program_unit(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd1023);
		drain_unit();

		// c = -2 sits exactly on the escape radius and never leaves it; c = 2
		// touches it once and then escapes; larger points escape at once or
		// saturate. A step of 4.0 walks through these along the first row.
		program_unit(32'hE000_0000, 32'h0000_0000, 32'h4000_0000, 32'd20);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd0, 10'd1);
		send_pixel(10'd0, 10'd2);
		send_pixel(10'd0, 10'd1023);
		send_pixel(10'd1, 10'd0);
		drain_unit();

		// Largest limit with saturated coordinates: escape on the first check.
		program_unit(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_FFFF);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd1023);
		drain_unit();

		// Zero step and the largest limit at c = 0: one long inside pixel.
		program_unit(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'hA5A5_FFFF);
		send_pixel(10'd0, 10'd0);
		drain_unit();

		// Random views. Most look at the set itself so counts vary widely; some
		// zoom onto a small patch near its edge, some use raw register values.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				re = 32'(-671088640 + int'($urandom_range(0, 268435456)));
				im = 32'(-402653184 + int'($urandom_range(0, 268435456)));
				stp = $urandom_range(65536, 1048576);
			end else if (pick < 8) begin
				re = 32'(-201326592 + int'($urandom_range(0, 1048576)));
				im = 32'(26843545 + int'($urandom_range(0, 1048576)));
				stp = $urandom_range(0, 256);
			end else begin
				re = $urandom;
				im = $urandom;
				stp = $urandom;
			end
			pick = $urandom_range(0, 9);
			if (pick < 5) begin
				lim = 16'($urandom_range(1, 64));
			end else if (pick < 8) begin
				lim = 16'($urandom_range(65, 300));
			end else if (pick < 9) begin
				lim = 16'($urandom_range(0, 3));
			end else begin
				lim = 16'($urandom_range(256, 520));
			end
			program_unit(re, im, stp, {16'($urandom), lim});
			gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
			for (int n = 0; n < PHASE_PIXELS; n++) begin
				// Now and then hold the stream back until the unit has emptied.
				if ($urandom_range(0, 49) == 0) begin
					drain_unit();
				end
				pick = $urandom_range(0, 19);
				row = (pick == 0) ? 10'd1023 : (pick == 1) ? 10'd0 : 10'($urandom);
				col = (pick == 2) ? 10'd1023 : (pick == 3) ? 10'd0 : 10'($urandom);
				send_pixel(row, col);
			end
			drain_unit();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/met_pkg.sv
rtl/core/met_ctrl.sv
rtl/core/met_dp.sv
rtl/core/mandelbrot_escape_time_unit.sv
test/mandelbrot_escape_time_checker.sv
test/mandelbrot_escape_time_unit_tb.sv
